/* rtl/core/ilis_pkg.sv */
// ----------------------------------------------------------------------------
// ilis_pkg
// Shared types and constants for the indexed list insert/remove/search unit:
// payload structs, opcodes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package ilis_pkg;

  // default number of list entries
  localparam int DEF_CAPACITY = 16;

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // input transaction payload
  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic       ok;
    logic [3:0] found_position;
    logic [4:0] length;
  } out_item_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_CHK,
    ST_INS_WR,
    ST_INS_PUT,
    ST_REM_CHK,
    ST_REM_WR,
    ST_REM_END,
    ST_SRCH_CHK,
    ST_SRCH_CMP,
    ST_FINISH
  } state_t;

  // walking index update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // ram read address select
  typedef enum logic [1:0] {
    RD_PREV,
    RD_NEXT,
    RD_CUR
  } rd_sel_t;

  // ram write address/data select
  typedef enum logic {
    WR_SHIFT,
    WR_NEW
  } wr_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_clr;
    logic    res_hit;
    logic    out_load;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       ins_ok;
    logic       rem_ok;
    logic       idx_gt_pos;
    logic       rem_more;
    logic       srch_more;
    logic       match;
  } dp_status_t;

endpackage

/* rtl/core/indexed_list_insert_remove_search_unit.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_search_unit
// Ordered list of up to CAPACITY signed 32-bit values with insert, remove
// and search commands; one result per command.
// ----------------------------------------------------------------------------
// Usage:
// - in_valid/in_ready carry a command transaction (opcode, position,
//   item_value); out_valid/out_ready carry its result (ok, found_position,
//   length). Exactly one result per command, in order.
// - One command is in work at a time; in_ready is high only while idle.
// - Each moved or compared entry takes a registered ram read, followed by
//   a write (insert, remove) or a compare (search).
// - The next command is accepted in the cycle after the result is
//   registered, so commands never overlap.
// - The result sits in an output register; while it waits for out_ready
//   the next command is still accepted and worked on, its result is held
//   back until the register is free and in_ready stays low meanwhile.
// - Reset empties the list (count zero); entry contents are not cleared and
//   need no clearing pass, since only entries below the count are read.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_search_unit #(
  parameter int CAPACITY = ilis_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilis_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ilis_pkg::out_item_t out_data
);
  import ilis_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing and handshakes
  ilis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, compare and result
  ilis_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

/* rtl/core/ilis_ram.sv */
// ----------------------------------------------------------------------------
// ilis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ilis_dpath.sv */
// ----------------------------------------------------------------------------
// ilis_dpath
// Datapath: command capture, entry count, walking index, entry RAM,
// comparator and the result register.
// ----------------------------------------------------------------------------
module ilis_dpath #(
  parameter int CAPACITY = ilis_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ilis_pkg::in_item_t  in_data,
  input  ilis_pkg::ctrl_cmd_t cmd,
  output ilis_pkg::dp_status_t status,
  output ilis_pkg::out_item_t out_data
);
  import ilis_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  logic [1:0]         op_r;
  logic [4:0]         pos_r;
  logic [31:0]        val_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               ok_r;
  logic [CW-1:0]      where_r;
  out_item_t          out_data_r;

  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      count_ext;
  logic [PW-1:0]      idx_ext;
  logic [CW:0]        idx_plus1;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic [31:0]        rd_data;
  logic [31:0]        where_wide;
  logic [31:0]        count_wide;

  // widened views for compares
  assign pos_ext   = PW'(pos_r);
  assign count_ext = PW'(count_r);
  assign idx_ext   = PW'(idx_r);
  assign idx_plus1 = (CW + 1)'(idx_r) + (CW + 1)'(1);

  // captured command
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      pos_r <= in_data.position;
      val_r <= $unsigned(in_data.item_value);
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // walking index
  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD:  idx_nxt = idx_r;
      IDX_COUNT: idx_nxt = count_r;
      IDX_POS:   idx_nxt = pos_ext[CW-1:0];
      IDX_ZERO:  idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_r + CW'(1);
      IDX_DEC:   idx_nxt = idx_r - CW'(1);
      default:   idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // ram address and data selection
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_addr = AW'(idx_r - CW'(1));
      RD_NEXT: rd_addr = AW'(idx_plus1);
      RD_CUR:  rd_addr = AW'(idx_r);
      default: rd_addr = AW'(idx_r);
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_SHIFT: begin
        wr_addr = AW'(idx_r);
        wr_data = rd_data;
      end
      WR_NEW: begin
        wr_addr = AW'(pos_ext);
        wr_data = val_r;
      end
      default: begin
        wr_addr = AW'(idx_r);
        wr_data = rd_data;
      end
    endcase
  end

  // entry storage
  ilis_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // result flag and match position
  always_ff @(posedge clk) begin
    if (cmd.res_clr) begin
      ok_r    <= 1'b0;
      where_r <= '0;
    end else if (cmd.res_hit) begin
      ok_r    <= 1'b1;
      where_r <= (op_r == OP_SEARCH) ? idx_r : '0;
    end
  end

  // result register
  assign where_wide = 32'(where_r);
  assign count_wide = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.ok             <= ok_r;
      out_data_r.found_position <= where_wide[3:0];
      out_data_r.length         <= count_wide[4:0];
    end
  end

  assign out_data = out_data_r;

  // status to controller
  always_comb begin
    status.opcode     = op_r;
    status.ins_ok     = (pos_ext <= count_ext) && (count_ext < PW'(CAPACITY));
    status.rem_ok     = pos_ext < count_ext;
    status.idx_gt_pos = idx_ext > pos_ext;
    status.rem_more   = idx_plus1 < (CW + 1)'(count_r);
    status.srch_more  = idx_r < count_r;
    status.match      = rd_data == val_r;
  end

endmodule

/* rtl/core/ilis_ctrl.sv */
// ----------------------------------------------------------------------------
// ilis_ctrl
// Controller: handshakes and the sequence of shift, compare and update steps
// for one command at a time.
// ----------------------------------------------------------------------------
module ilis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ilis_pkg::dp_status_t status,
  output ilis_pkg::ctrl_cmd_t  cmd
);
  import ilis_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.rd_sel    = RD_CUR;
    cmd.wr_sel    = WR_SHIFT;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.res_clr = 1'b1;
        if (status.opcode == OP_INSERT && status.ins_ok) begin
          cmd.idx_op = IDX_COUNT;
          state_nxt  = ST_INS_CHK;
        end else if (status.opcode == OP_REMOVE && status.rem_ok) begin
          cmd.idx_op = IDX_POS;
          state_nxt  = ST_REM_CHK;
        end else if (status.opcode == OP_SEARCH) begin
          cmd.idx_op = IDX_ZERO;
          state_nxt  = ST_SRCH_CHK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      // insert: move entries up from the tail down to the slot
      ST_INS_CHK: begin
        if (status.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_nxt  = ST_INS_WR;
        end else begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.idx_op = IDX_DEC;
        state_nxt  = ST_INS_CHK;
      end
      ST_INS_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.res_hit = 1'b1;
        state_nxt   = ST_FINISH;
      end
      // remove: move entries down over the removed slot
      ST_REM_CHK: begin
        if (status.rem_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_nxt  = ST_REM_WR;
        end else begin
          state_nxt = ST_REM_END;
        end
      end
      ST_REM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.idx_op = IDX_INC;
        state_nxt  = ST_REM_CHK;
      end
      ST_REM_END: begin
        cmd.cnt_dec = 1'b1;
        cmd.res_hit = 1'b1;
        state_nxt   = ST_FINISH;
      end
      // search: read and compare one entry per pass
      ST_SRCH_CHK: begin
        if (status.srch_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_nxt  = ST_SRCH_CMP;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SRCH_CMP: begin
        if (status.match) begin
          cmd.res_hit = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = ST_SRCH_CHK;
        end
      end
      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* tb/tb_indexed_list_insert_remove_search_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove_search_unit
// Self-checking bench for the indexed list unit. A shadow copy of the list
// predicts ok, found position and length for every accepted command. Results
// are compared in order. Directed corner cases come first, then a long random
// run that fills and drains the list. Both handshakes see random gaps, and
// the result side holds off for a long stretch so that the unit backs up.
// ----------------------------------------------------------------------------

package ilis_tb_pkg;
  import ilis_pkg::*;

  // opcode with no function in the unit
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIST_DEPTH = DEF_CAPACITY;

  // shadow list plus the queue of results still owed by the unit
  class list_shadow;
    logic signed [31:0] slots [LIST_DEPTH];
    int unsigned        held;
    out_item_t          pending_results [$];
    int unsigned        mismatches;
    int unsigned        results_checked;

    function new();
      held = 0;
      mismatches = 0;
      results_checked = 0;
      foreach (slots[k]) slots[k] = '0;
    endfunction

    function int unsigned length();
      return held;
    endfunction

    function logic signed [31:0] slot_at(int unsigned idx);
      return slots[idx];
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // apply one accepted command to the shadow list and queue its result
    function void note_command(in_item_t cmd);
      out_item_t   res;
      int unsigned pos;
      int unsigned i;
      res = '0;
      pos = cmd.position;
      case (cmd.opcode)
        OP_INSERT: begin
          if (pos <= held && held < LIST_DEPTH) begin
            for (i = held; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = cmd.item_value;
            held++;
            res.ok = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (pos < held) begin
            for (i = pos; i + 1 < held; i++) slots[i] = slots[i + 1];
            held--;
            res.ok = 1'b1;
          end
        end
        OP_SEARCH: begin
          for (i = 0; i < held; i++) begin
            if (slots[i] == cmd.item_value) begin
              res.ok = 1'b1;
              res.found_position = 4'(i);
              break;
            end
          end
        end
        default: begin
          // unused opcode leaves the list alone
        end
      endcase
      res.length = 5'(held);
      pending_results.push_back(res);
    endfunction

    // compare one result transaction against the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok=%0d pos=%0d len=%0d",
                 $time, got.ok, got.found_position, got.length);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok) begin
        $display("%0t: ok mismatch, expected %0d, actual %0d", $time, want.ok, got.ok);
        mismatches++;
      end
      if (got.found_position !== want.found_position) begin
        $display("%0t: found_position mismatch, expected %0d, actual %0d",
                 $time, want.found_position, got.found_position);
        mismatches++;
      end
      if (got.length !== want.length) begin
        $display("%0t: length mismatch, expected %0d, actual %0d",
                 $time, want.length, got.length);
        mismatches++;
      end
    endfunction
  endclass
endpackage

module tb_indexed_list_insert_remove_search_unit;
  import ilis_pkg::*;
  import ilis_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1625;
  localparam int IDLE_PCT     = 17;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  list_shadow shadow;
  bit         quiet;

  indexed_list_insert_remove_search_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hard stop in case the unit hangs
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_item_t make_cmd(logic [1:0] op, logic [4:0] pos,
                                        logic signed [31:0] val);
    in_item_t cmd;
    cmd.opcode     = op;
    cmd.position   = pos;
    cmd.item_value = val;
    return cmd;
  endfunction

  // values drawn often from a small pool so searches hit and duplicates occur
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom;
    case ($urandom_range(0, 7))
      0: return 32'sd0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return 32'sh8000_0000;
      4: return 32'sh7fff_ffff;
      5: return 32'sd7;
      6: return 32'sd42;
      default: return -32'sd100;
    endcase
  endfunction

  // offer one command; entered and left at a falling edge
  task automatic send_command(in_item_t cmd);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    shadow.note_command(cmd);
    @(negedge clk);
  endtask

  // result side: random stalls plus long hold-offs to back the unit up
  initial begin
    int unsigned hold_left;
    int unsigned next_hold_at;
    out_ready    = 1'b0;
    hold_left    = 0;
    next_hold_at = 150;
    forever begin
      @(negedge clk);
      if (shadow != null && shadow.results_checked >= next_hold_at) begin
        hold_left    = HOLD_CYCLES;
        next_hold_at = next_hold_at + 1000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_result(out_data);
  end

  // stimulus
  initial begin
    int unsigned        n;
    int unsigned        k;
    int unsigned        roll;
    int unsigned        len;
    bit                 filling;
    logic [1:0]         op;
    logic [4:0]         pos;
    logic signed [31:0] val;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    quiet    = 1'b0;
    shadow   = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // empty list corners
    send_command(make_cmd(OP_REMOVE, 5'd0, 32'sd0));
    send_command(make_cmd(OP_SEARCH, 5'd0, 32'sd5));
    send_command(make_cmd(OP_INSERT, 5'd1, 32'sd9));
    send_command(make_cmd(OP_UNUSED, 5'd31, 32'sh7fff_ffff));

    // extremes at front, back and middle
    send_command(make_cmd(OP_INSERT, 5'd0, 32'sh8000_0000));
    send_command(make_cmd(OP_INSERT, 5'd1, 32'sh7fff_ffff));
    send_command(make_cmd(OP_INSERT, 5'd1, 32'sd0));

    // fill to capacity with repeated values
    for (k = 3; k < LIST_DEPTH; k++)
      send_command(make_cmd(OP_INSERT, 5'(k), (k % 2) ? 32'sd7 : -32'sd1));

    // full list, past-end insert, first of several matches, no match
    send_command(make_cmd(OP_INSERT, 5'd0, 32'sd3));
    send_command(make_cmd(OP_INSERT, 5'd31, 32'sd3));
    send_command(make_cmd(OP_SEARCH, 5'd31, 32'sd7));
    send_command(make_cmd(OP_SEARCH, 5'd0, 32'sd12345));

    // removes out of range, last and first
    send_command(make_cmd(OP_REMOVE, 5'd16, 32'sd0));
    send_command(make_cmd(OP_REMOVE, 5'd15, 32'sd0));
    send_command(make_cmd(OP_REMOVE, 5'd0, -32'sd1));

    // random part, alternating between filling and draining the list
    filling = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 500 && n < 800);
      if (n % 80 == 0) filling = ~filling;
      len  = shadow.length();
      roll = $urandom_range(0, 99);
      if (roll < 5) op = OP_UNUSED;
      else if (roll < (filling ? 60 : 30)) op = OP_INSERT;
      else if (roll < (filling ? 80 : 75)) op = OP_REMOVE;
      else op = OP_SEARCH;

      if ($urandom_range(0, 99) < 15) pos = 5'($urandom_range(0, 31));
      else if (op == OP_INSERT) pos = 5'($urandom_range(0, len));
      else if (op == OP_REMOVE) pos = (len > 0) ? 5'($urandom_range(0, len - 1)) : 5'd0;
      else pos = 5'($urandom_range(0, 31));

      if (op == OP_SEARCH && len > 0 && $urandom_range(0, 99) < 60)
        val = shadow.slot_at($urandom_range(0, len - 1));
      else
        val = pick_value();

      send_command(make_cmd(op, pos, val));
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // drain outstanding results, then watch for strays
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
